// ===== sv/tbs_pkg.sv =====
package tbs_pkg;

  localparam int MAX_LINE   = 16384;
  localparam int MAX_TOKENS = 4096;
  localparam int POS_W      = 15;
  localparam int WANT_W     = 13;
  localparam int CNT_W      = 14;
  localparam int RES_MAX    = 4;
  localparam int NUM_W      = 3;
  localparam int RES_IDX_W  = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef enum logic [1:0] {
    ST_BOUNDARY = 2'd0,
    ST_ENOUGH   = 2'd1,
    ST_FEW      = 2'd2
  } status_t;

  typedef enum logic {
    CFG_SCAN_MODE     = 1'b0,
    CFG_TOKENS_WANTED = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             end_flag;
    status_t          status;
  } result_t;

  // all results caused by one character, oldest in slot 0
  typedef struct packed {
    result_t [RES_MAX-1:0] res;
    logic [NUM_W-1:0]      num;
  } entry_t;

endpackage

// ===== sv/tbs_front.sv =====
module tbs_front import tbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [WANT_W-1:0] cfg_data,
  input  logic              push,
  input  logic              full,
  input  logic [7:0]        character,
  output logic              wr_en,
  output entry_t            wr_data
);

  typedef enum logic [1:0] {
    PHASE_WAIT   = 2'd0,
    PHASE_WORD   = 2'd1,
    PHASE_STRING = 2'd2
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   char_pos, char_pos_next;
  logic [CNT_W-1:0]   bcount, bcount_next;
  logic               done, done_next;
  logic               scan_mode;
  logic [WANT_W-1:0]  tokens_wanted;

  logic               accept;
  logic               is_term, is_ws, is_punct, is_quote;
  logic [WANT_W-1:0]  want;
  logic [CNT_W-1:0]   limit;
  logic [POS_W-1:0]   pos_inc;

  assign accept   = push && !full;
  assign is_term  = (character == CH_NUL);
  assign is_ws    = (character == CH_SPACE) || (character == CH_TAB) || (character == CH_NL);
  assign is_punct = (character == CH_LPAREN) || (character == CH_RPAREN) ||
                    (character == CH_LBRACE) || (character == CH_EQUAL) ||
                    (character == CH_SEMI);
  assign is_quote = (character == CH_QUOTE);

  always_comb begin
    if (tokens_wanted == '0) begin
      want = WANT_W'(1);
    end else if (tokens_wanted > WANT_W'(MAX_TOKENS)) begin
      want = WANT_W'(MAX_TOKENS);
    end else begin
      want = tokens_wanted;
    end
  end

  assign limit   = {want, 1'b0};
  assign pos_inc = (char_pos == POS_W'(MAX_LINE)) ? char_pos : char_pos + POS_W'(1);

  always_comb begin
    logic [2:0]             cand_valid;
    logic [2:0][POS_W-1:0]  cand_pos;
    logic [2:0]             cand_end;
    logic [CNT_W-1:0]       c;
    logic                   d;
    logic [NUM_W-1:0]       n;
    logic                   term_close;
    entry_t                 e;

    cand_valid    = '0;
    cand_pos      = '0;
    cand_end      = '0;
    term_close    = 1'b0;
    phase_next    = phase;
    char_pos_next = char_pos;

    if (is_term) begin
      if (!done && (phase != PHASE_WAIT) && (CNT_W'(bcount + CNT_W'(1)) == limit)) begin
        term_close    = 1'b1;
        cand_valid[0] = 1'b1;
        cand_pos[0]   = char_pos;
        cand_end[0]   = 1'b1;
      end
    end else if (!done) begin
      char_pos_next = pos_inc;
      if (scan_mode && (phase != PHASE_STRING) && (is_punct || is_quote)) begin
        // close a running word before the punctuation or opening quote
        cand_valid[0] = (phase == PHASE_WORD);
        cand_pos[0]   = char_pos;
        cand_end[0]   = 1'b1;
        cand_valid[1] = 1'b1;
        cand_pos[1]   = char_pos;
        cand_end[1]   = 1'b0;
        cand_valid[2] = is_punct;
        cand_pos[2]   = pos_inc;
        cand_end[2]   = 1'b1;
        phase_next    = is_punct ? PHASE_WAIT : PHASE_STRING;
      end else begin
        case (phase)
          PHASE_WAIT: begin
            if (!is_ws) begin
              cand_valid[1] = 1'b1;
              cand_pos[1]   = char_pos;
              phase_next    = PHASE_WORD;
            end
          end
          PHASE_WORD: begin
            if (is_ws) begin
              cand_valid[0] = 1'b1;
              cand_pos[0]   = char_pos;
              cand_end[0]   = 1'b1;
              phase_next    = PHASE_WAIT;
            end
          end
          PHASE_STRING: begin
            if (scan_mode && is_quote) begin
              cand_valid[2] = 1'b1;
              cand_pos[2]   = pos_inc;
              cand_end[2]   = 1'b1;
              phase_next    = PHASE_WAIT;
            end
          end
          default: begin
            phase_next = PHASE_WAIT;
          end
        endcase
      end
    end

    c = bcount;
    d = done;
    n = '0;
    e = '0;
    for (int j = 0; j < 3; j++) begin
      if (cand_valid[j] && !d) begin
        e.res[n[RES_IDX_W-1:0]] = '{pos: cand_pos[j], end_flag: cand_end[j],
                                    status: ST_BOUNDARY};
        n = n + NUM_W'(1);
        c = c + CNT_W'(1);
        if (c >= limit) begin
          e.res[n[RES_IDX_W-1:0]] = '{pos: char_pos, end_flag: 1'b0, status: ST_ENOUGH};
          n = n + NUM_W'(1);
          d = 1'b1;
        end
      end
    end

    if (is_term && !done && !term_close) begin
      e.res[n[RES_IDX_W-1:0]] = '{pos: char_pos, end_flag: 1'b0,
                                  status: (bcount >= limit) ? ST_ENOUGH : ST_FEW};
      n = n + NUM_W'(1);
    end
    e.num = n;

    if (is_term) begin
      phase_next    = PHASE_WAIT;
      char_pos_next = '0;
      bcount_next   = '0;
      done_next     = 1'b0;
    end else begin
      bcount_next = c;
      done_next   = d;
    end

    wr_data = e;
    wr_en   = accept && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_WAIT;
      char_pos      <= '0;
      bcount        <= '0;
      done          <= 1'b0;
      scan_mode     <= 1'b1;
      tokens_wanted <= WANT_W'(1);
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SCAN_MODE:     scan_mode     <= cfg_data[0];
          CFG_TOKENS_WANTED: tokens_wanted <= cfg_data;
          default:           scan_mode     <= scan_mode;
        endcase
      end
      if (accept) begin
        phase    <= phase_next;
        char_pos <= char_pos_next;
        bcount   <= bcount_next;
        done     <= done_next;
      end
    end
  end

endmodule

// ===== sv/tbs_queue.sv =====
module tbs_queue import tbs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/tbs_back.sv =====
module tbs_back import tbs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  entry_t           head,
  input  logic             q_empty,
  output logic             q_rd,
  input  logic             pop,
  output logic             empty,
  output logic [POS_W-1:0] boundary_pos,
  output logic             boundary_end,
  output logic [1:0]       status,
  output logic             last_of_run
);

  logic [RES_IDX_W-1:0] idx;
  logic                 last;
  logic                 take;
  result_t              cur;

  assign cur          = head.res[idx];
  assign last         = ({1'b0, idx} == (head.num - NUM_W'(1)));
  assign take         = pop && !q_empty;
  assign q_rd         = take && last;
  assign empty        = q_empty;
  assign boundary_pos = cur.pos;
  assign boundary_end = cur.end_flag;
  assign status       = cur.status;
  assign last_of_run  = last;

  // walk through the results of the head entry, one word per pop
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? '0 : idx + RES_IDX_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_head_nonzero: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (head.num != '0))
    else $error("queued entry holds no result");
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> ({1'b0, idx} < head.num))
    else $error("result index past entry count");
  a_idx_rewinds: assert property (@(posedge clk) disable iff (rst)
    q_rd |=> (idx == '0))
    else $error("result index not rewound after last word");
`endif

endmodule

// ===== sv/token_boundary_scanner_core.sv =====
// Token boundary scanner. Feed a line one byte per push, ended by a zero byte; each
// byte is accepted while full is low and yields zero to four result words (token start and
// end positions, then an "enough tokens" or "too few tokens" status), with
// last_of_run marking the final word of that byte. Results drain one word per pop
// from a FIFO_DEPTH-entry queue of per-byte result groups; the input sees full only
// when that queue is full, so a new byte is taken every cycle, while results are still
// being read, as long as the queue is not full. With the queue empty, a byte's first
// result can be popped in the cycle after the byte is accepted. Registers (scan_mode,
// tokens_wanted) are written through the cfg port, always ready, and should only change while the block is idle.
module token_boundary_scanner_core import tbs_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [WANT_W-1:0] cfg_data,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        character,
  output logic              empty,
  input  logic              pop,
  output logic [POS_W-1:0]  boundary_pos,
  output logic              boundary_end,
  output logic [1:0]        status,
  output logic              last_of_run
);

  logic   wr_en;
  entry_t wr_data;
  entry_t head;
  logic   q_rd;
  logic   q_empty;

  assign cfg_ready = 1'b1;

  tbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .character (character),
    .wr_en     (wr_en),
    .wr_data   (wr_data)
  );

  tbs_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (q_rd),
    .rd_data (head),
    .full    (full),
    .empty   (q_empty)
  );

  tbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .boundary_pos (boundary_pos),
    .boundary_end (boundary_end),
    .status       (status),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== bench/tb_token_boundary_scanner_core.sv =====
`timescale 1ns / 100ps

module tb_token_boundary_scanner_core;
  import tbs_pkg::*;

  localparam int unsigned MODE_WORDS = 0;
  localparam int unsigned MODE_PUNCT = 1;
  localparam int LONG_HOLD = 150;
  localparam int IDLE_TAIL = 4;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_WORD   = 2'd1,
    PH_STRING = 2'd2
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             end_flag;
    status_t          st;
    logic             last_flag;
  } boundary_word_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_index_t        cfg_index;
  logic [WANT_W-1:0] cfg_data;
  logic              push;
  logic              full;
  logic [7:0]        character;
  logic              empty;
  logic              pop;
  logic [POS_W-1:0]  boundary_pos;
  logic              boundary_end;
  logic [1:0]        status;
  logic              last_of_run;

  token_boundary_scanner_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .character    (character),
    .empty        (empty),
    .pop          (pop),
    .boundary_pos (boundary_pos),
    .boundary_end (boundary_end),
    .status       (status),
    .last_of_run  (last_of_run)
  );

  // scanner state as the block should hold it
  int unsigned       mode_q;
  int unsigned       want_q;
  phase_t            phase_q;
  int unsigned       pos_q;
  int unsigned       count_q;
  int unsigned       limit_q;
  bit                done_q;

  boundary_word_t expected_words[$];
  boundary_word_t run_buf[RES_MAX];
  int             run_n;

  int errors = 0;
  int sent_items = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd2_000_000);
    $display("token_boundary_scanner_core test failed");
    $finish;
  end

  function automatic void clear_line();
    phase_q = PH_WAIT;
    pos_q = 0;
    count_q = 0;
    done_q = 1'b0;
  endfunction

  function automatic void add_word(input int unsigned p, input logic e, input status_t s);
    boundary_word_t w;
    if (p > MAX_LINE) p = MAX_LINE;
    w.pos = p[POS_W-1:0];
    w.end_flag = e;
    w.st = s;
    w.last_flag = 1'b0;
    run_buf[run_n] = w;
    run_n++;
  endfunction

  function automatic void add_boundary(input int unsigned p, input logic e);
    if (done_q) return;
    add_word(p, e, ST_BOUNDARY);
    count_q++;
    if (count_q >= limit_q) begin
      add_word(pos_q, 1'b0, ST_ENOUGH);
      done_q = 1'b1;
    end
  endfunction

  // advance the scanner by one byte and queue the words it produces
  function automatic void scan_char(input logic [7:0] c);
    int unsigned i;
    int unsigned want;
    bit space;
    bit punct;
    int k;
    boundary_word_t w;
    i = pos_q;
    want = want_q;
    space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    punct = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
            (c == CH_EQUAL) || (c == CH_SEMI);
    if (want < 1) want = 1;
    if (want > MAX_TOKENS) want = MAX_TOKENS;
    limit_q = 2 * want;
    run_n = 0;
    if (c == CH_NUL) begin
      if (!done_q) begin
        if (phase_q != PH_WAIT && count_q + 1 == limit_q) add_boundary(i, 1'b1);
        else if (count_q >= limit_q) add_word(i, 1'b0, ST_ENOUGH);
        else add_word(i, 1'b0, ST_FEW);
      end
      clear_line();
    end else if (!done_q) begin
      if (mode_q == MODE_PUNCT && phase_q != PH_STRING && punct) begin
        if (phase_q == PH_WORD) add_boundary(i, 1'b1);
        add_boundary(i, 1'b0);
        add_boundary(i + 1, 1'b1);
        phase_q = PH_WAIT;
      end else if (mode_q == MODE_PUNCT && phase_q != PH_STRING && c == CH_QUOTE) begin
        if (phase_q == PH_WORD) add_boundary(i, 1'b1);
        add_boundary(i, 1'b0);
        phase_q = PH_STRING;
      end else if (phase_q == PH_WAIT) begin
        if (!space) begin
          add_boundary(i, 1'b0);
          phase_q = PH_WORD;
        end
      end else if (phase_q == PH_WORD) begin
        if (space) begin
          add_boundary(i, 1'b1);
          phase_q = PH_WAIT;
        end
      end else if (mode_q == MODE_PUNCT && c == CH_QUOTE) begin
        // string stays open in word mode; only punctuation mode closes it
        add_boundary(i + 1, 1'b1);
        phase_q = PH_WAIT;
      end
      if (pos_q < MAX_LINE) pos_q++;
    end
    for (k = 0; k < run_n; k++) begin
      w = run_buf[k];
      w.last_flag = (k == run_n - 1);
      expected_words.push_back(w);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    boundary_word_t w;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, actual pos=%0d end=%0d st=%0d last=%0d",
                 $time, boundary_pos, boundary_end, status, last_of_run);
        errors++;
      end else begin
        w = expected_words.pop_front();
        compare_field("boundary_pos", 16'(w.pos), 16'(boundary_pos));
        compare_field("boundary_end", 16'(w.end_flag), 16'(boundary_end));
        compare_field("status", 16'(w.st), 16'(status));
        compare_field("last_of_run", 16'(w.last_flag), 16'(last_of_run));
      end
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : receiver
    int n;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        pop <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    character <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    scan_char(c);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= WANT_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCAN_MODE) mode_q = {31'b0, val[0]};
    else want_q = {{(32 - WANT_W){1'b0}}, val[WANT_W-1:0]};
    @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_text("(a");
    send_char(CH_NUL);
    send_text("ab");
    send_char(CH_NUL);
    // string still open at the terminator
    send_text("\"ab");
    send_char(CH_NUL);
  endtask

  task automatic test_word_mode();
    wait_idle();
    write_reg(CFG_SCAN_MODE, MODE_WORDS);
    write_reg(CFG_TOKENS_WANTED, 3);
    send_text(" a(b\t\"c\n");
    send_char(8'hff);
    send_char(8'h01);
    send_char(CH_NUL);
    send_text("x ");
    send_char(CH_NUL);
  endtask

  task automatic test_punctuation();
    wait_idle();
    write_reg(CFG_SCAN_MODE, MODE_PUNCT);
    write_reg(CFG_TOKENS_WANTED, 8);
    send_text("ab;\"x y\"={)(cd\"e");
    send_char(CH_NUL);
    send_text("(\t)");
    send_char(CH_NUL);
  endtask

  task automatic test_count_clamp();
    wait_idle();
    write_reg(CFG_TOKENS_WANTED, 0);
    send_text("q");
    send_char(CH_NUL);
    wait_idle();
    write_reg(CFG_TOKENS_WANTED, 13'h1fff);
    send_text("a b");
    send_char(CH_NUL);
  endtask

  task automatic test_midline_writes();
    wait_idle();
    write_reg(CFG_TOKENS_WANTED, 4);
    send_text("\"ab");
    wait_idle();
    write_reg(CFG_SCAN_MODE, MODE_WORDS);
    send_text("c\" d");
    wait_idle();
    write_reg(CFG_SCAN_MODE, MODE_PUNCT);
    send_text("\" ef g");
    wait_idle();
    // count already past the new target: stops at the next boundary
    write_reg(CFG_TOKENS_WANTED, 2);
    send_text("h x");
    send_char(CH_NUL);
    wait_idle();
    write_reg(CFG_TOKENS_WANTED, 3);
    send_text("a b c");
    wait_idle();
    write_reg(CFG_TOKENS_WANTED, 1);
    send_char(CH_NUL);
  endtask

  // count completed by the terminator closing a word, then by punctuation
  // with the rest of the line ignored
  task automatic test_count_at_end();
    int k;
    wait_idle();
    write_reg(CFG_TOKENS_WANTED, 6);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (k = 0; k < 5; k++) send_char(CH_SEMI);
    send_text(" a");
    send_char(CH_NUL);
    for (k = 0; k < 6; k++) send_char(CH_SEMI);
    send_char("a");
    send_char(CH_NUL);
  endtask

  task automatic test_backpressure();
    int k;
    wait_idle();
    write_reg(CFG_TOKENS_WANTED, 200);
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_char((k % 2) ? CH_LPAREN : "x");
    send_char(CH_NUL);
  endtask

  task automatic send_random_line();
    int len;
    int k;
    int r;
    logic [7:0] c;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        c = 8'($urandom_range(8'h61, 8'h7a));
      end else if (r < 52) begin
        case ($urandom_range(0, 2))
          0: c = CH_SPACE;
          1: c = CH_TAB;
          default: c = CH_NL;
        endcase
      end else if (r < 68) begin
        case ($urandom_range(0, 4))
          0: c = CH_LPAREN;
          1: c = CH_RPAREN;
          2: c = CH_LBRACE;
          3: c = CH_EQUAL;
          default: c = CH_SEMI;
        endcase
      end else if (r < 76) begin
        c = CH_QUOTE;
      end else if (r < 97) begin
        c = 8'($urandom_range(1, 255));
      end else begin
        c = CH_NUL;
      end
      send_char(c);
    end
    send_char(CH_NUL);
  endtask

  task automatic test_random(input int target, input bit steady);
    int start;
    int r;
    start = sent_items;
    while (sent_items - start < target) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        if ($urandom_range(0, 1)) write_reg(CFG_SCAN_MODE, $urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 70) write_reg(CFG_TOKENS_WANTED, $urandom_range(1, 5));
        else if (r < 80) write_reg(CFG_TOKENS_WANTED, $urandom_range(6, 40));
        else if (r < 85) write_reg(CFG_TOKENS_WANTED, 0);
        else if (r < 90) write_reg(CFG_TOKENS_WANTED, 13'h1fff);
        else if (r < 95) write_reg(CFG_TOKENS_WANTED, MAX_TOKENS);
        else write_reg(CFG_TOKENS_WANTED, $urandom_range(0, 8191));
      end
      if (!steady) begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
      end
      send_random_line();
    end
  endtask

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    character <= CH_NUL;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SCAN_MODE;
    cfg_data <= '0;
    mode_q = MODE_PUNCT;
    want_q = 1;
    clear_line();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_word_mode();
    test_punctuation();
    test_count_clamp();
    test_midline_writes();
    test_count_at_end();
    test_backpressure();
    test_random(270, 1'b0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random(60, 1'b1);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("token_boundary_scanner_core test passed");
    end else begin
      $display("token_boundary_scanner_core test failed");
    end
    $finish;
  end

endmodule
